>>> design/rrq_pkg.sv
`default_nettype none

package rrq_pkg;

	// action codes of an input item
	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_POLL    = 2'd1,
		ACT_REPLY   = 2'd2,
		ACT_TICK    = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic [0:0] CFG_REPLY_TIMEOUT = 1'b0;
	localparam logic [0:0] CFG_SEND_ATTEMPTS = 1'b1;

	localparam int          CFG_DATA_BITS     = 16;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd250;
	localparam logic [3:0]  ATTEMPTS_RESET    = 4'd2;
	localparam logic [15:0] SAT_16            = 16'hFFFF;
	localparam int          WORD_BITS         = 64;

	typedef struct packed {
		action_t     action;
		logic [63:0] request_word;
		logic        slot_window_open;
	} req_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [63:0] send_word;
		logic        busy_res;
		logic        enqueue_accepted;
		logic [2:0]  queued_count;
		logic [15:0] timeout_total;
	} res_item_t;

	typedef struct packed {
		logic [15:0] reply_timeout_ms;
		logic [3:0]  send_attempts;
	} cfg_t;

endpackage

`default_nettype wire

>>> design/request_retry_queue.sv
// Request retry queue: a stop-and-wait sender holding up to RING_DEPTH request
// packets of ENTRY_BITS bits in a ring. Each item (enqueue, poll, reply or
// millisecond tick) gives exactly one result item. The item is registered on
// entry; the queue state is updated and the result is registered as it
// moves on from that register, which a held result can delay. send_word comes
// from the ring RAM's registered read port in step with the result
// register. One item is taken every cycle while the result side keeps
// up. Configuration (reply timeout, send attempts) is written through
// cfg_we/cfg_index/cfg_data with no handshake and must only change while
// no item is in flight. Ring entries hold no reset value; only packets that
// were enqueued are ever sent, and send_word reads zero when send_valid is low.
`default_nettype none

module request_retry_queue #(
	parameter int RING_DEPTH = 4,
	parameter int ENTRY_BITS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request channel
	input  wire logic                              req_valid,
	output      logic                              req_ready,
	input  wire rrq_pkg::req_item_t                req,
	// result channel
	output      logic                              res_valid,
	input  wire logic                              res_ready,
	output      rrq_pkg::res_item_t                res,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [0:0]                        cfg_index,
	input  wire logic [rrq_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	rrq_pkg::cfg_t      cfg_q;
	rrq_pkg::req_item_t req_s1;
	rrq_pkg::res_item_t core_res;
	rrq_pkg::res_item_t res_s2;
	logic               valid_s1, valid_s2;
	logic               adv_s2, fire_s1, req_fire;
	logic [ENTRY_BITS-1:0] rd_data;

	// result stage frees when empty or taken; the input stage moves on then
	assign adv_s2    = !valid_s2 || res_ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req_ready = !valid_s1 || fire_s1;
	assign req_fire  = req_valid && req_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reply_timeout_ms <= rrq_pkg::TIMEOUT_RESET;
			cfg_q.send_attempts    <= rrq_pkg::ATTEMPTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrq_pkg::CFG_REPLY_TIMEOUT: cfg_q.reply_timeout_ms <= cfg_data[15:0];
				rrq_pkg::CFG_SEND_ATTEMPTS: cfg_q.send_attempts    <= cfg_data[3:0];
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (fire_s1) begin
			res_s2 <= core_res;
		end
	end

	rrq_core #(
		.RING_DEPTH(RING_DEPTH),
		.ENTRY_BITS(ENTRY_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (req_s1),
		.cfg    (cfg_q),
		.res    (core_res),
		.rd_data(rd_data)
	);

	// the RAM read data register only loads on a send, so it holds under stall
	always_comb begin
		res           = res_s2;
		res.send_word = res_s2.send_valid ? rrq_pkg::WORD_BITS'(rd_data) : '0;
	end

	assign res_valid = valid_s2;

	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && valid_s2 && !res_ready)
		else $error("input stalled with room downstream");

endmodule

`default_nettype wire

>>> design/rrq_ram.sv
`default_nettype none

module rrq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> design/rrq_core.sv
`default_nettype none

// Queue state and the per-item update; ring entries live in a RAM whose
// registered read lines up with the result register of the top level.
module rrq_core #(
	parameter int RING_DEPTH = 4,
	parameter int ENTRY_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire rrq_pkg::req_item_t    item,
	input  wire rrq_pkg::cfg_t         cfg,
	output      rrq_pkg::res_item_t    res,
	output      logic [ENTRY_BITS-1:0] rd_data
);

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	logic [AW-1:0]    head_q, tail_q;
	logic [CNT_W-1:0] held_q;
	logic [3:0]       attempts_q;
	logic [15:0]      elapsed_q, dropped_q;

	logic [AW-1:0]    head_d, tail_d;
	logic [CNT_W-1:0] held_d;
	logic [3:0]       attempts_d;
	logic [15:0]      elapsed_d, dropped_d;

	logic             sent, accepted, wr_en;
	logic [CNT_W+2:0] held_ext;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
		next_slot = (s == AW'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		held_d     = held_q;
		attempts_d = attempts_q;
		elapsed_d  = elapsed_q;
		dropped_d  = dropped_q;
		sent       = 1'b0;
		accepted   = 1'b0;
		wr_en      = 1'b0;
		case (item.action)
			rrq_pkg::ACT_ENQUEUE: begin
				if (held_q != CNT_W'(RING_DEPTH)) begin
					wr_en    = fire;
					tail_d   = next_slot(tail_q);
					held_d   = held_q + 1'b1;
					accepted = 1'b1;
				end
			end
			rrq_pkg::ACT_POLL: begin
				if (!item.slot_window_open && elapsed_q >= cfg.reply_timeout_ms) begin
					if (attempts_q != 4'd0) begin
						attempts_d = attempts_q - 4'd1;
						// last attempt spent: drop the head and count it
						if (attempts_d == 4'd0 && held_q != '0) begin
							held_d = held_q - 1'b1;
							head_d = next_slot(head_q);
							if (dropped_q != rrq_pkg::SAT_16) begin
								dropped_d = dropped_q + 16'd1;
							end
						end
					end
					if (attempts_d == 4'd0 && held_d != '0) begin
						attempts_d = (cfg.send_attempts == 4'd0) ? 4'd1 : cfg.send_attempts;
					end
					if (attempts_d != 4'd0) begin
						if (held_d != '0) begin
							sent      = 1'b1;
							elapsed_d = '0;
						end else begin
							attempts_d = 4'd0;
						end
					end
				end
			end
			rrq_pkg::ACT_REPLY: begin
				attempts_d = 4'd0;
				if (held_q != '0) begin
					held_d = held_q - 1'b1;
					head_d = next_slot(head_q);
				end
			end
			default: begin
				if (elapsed_q != rrq_pkg::SAT_16) begin
					elapsed_d = elapsed_q + 16'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			held_q     <= '0;
			attempts_q <= '0;
			elapsed_q  <= '0;
			dropped_q  <= '0;
		end else if (fire) begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			held_q     <= held_d;
			attempts_q <= attempts_d;
			elapsed_q  <= elapsed_d;
			dropped_q  <= dropped_d;
		end
	end

	// head_d is the slot to send after any drop on this item
	rrq_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(item.request_word[ENTRY_BITS-1:0]),
		.rd_en  (fire && sent),
		.rd_addr(head_d),
		.rd_data(rd_data)
	);

	assign held_ext = (CNT_W + 3)'(held_d);

	always_comb begin
		res                  = '0;
		res.send_valid       = sent;
		res.busy_res         = (attempts_d != 4'd0);
		res.enqueue_accepted = accepted;
		res.queued_count     = held_ext[2:0];
		res.timeout_total    = dropped_d;
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(RING_DEPTH))
		else $error("ring count above depth");

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		attempts_q != 4'd0 |-> held_q != '0)
		else $error("waiting for a reply with an empty ring");

	a_slots_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0 || held_q == CNT_W'(RING_DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with count");

	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sent |=> attempts_q != 4'd0)
		else $error("send without awaiting a reply");

endmodule

`default_nettype wire
